FILE: design/cell_linked_list_builder_macros.svh
// Assertion macros for the cell linked list builder.
`ifndef CELL_LINKED_LIST_BUILDER_MACROS_SVH
`define CELL_LINKED_LIST_BUILDER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CLLB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cllb assertion failed");

// Next-cycle implication, disabled in reset.
`define CLLB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cllb assertion failed");

`endif

FILE: design/cllb_pkg.sv
// Shared types and constants of the cell linked list builder.
`default_nettype none

package cllb_pkg;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 32;

  localparam logic [CFG_IW-1:0] REG_CELLS_PER_SIDE = 2'd0;
  localparam logic [CFG_IW-1:0] REG_CELL_SCALE     = 2'd1;
  localparam logic [CFG_IW-1:0] REG_OBJECT_COUNT   = 2'd2;

  typedef struct packed {
    logic clear;
    logic load;
    logic mul;
    logic clamp;
    logic row;
    logic flat;
    logic read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic full;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/cllb_ctrl.sv
// Sequencing state machine of the cell linked list builder.
`default_nettype none

module cllb_ctrl import cllb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_CLAMP = 8'b0000_1000,
    S_ROW   = 8'b0001_0000,
    S_CELL  = 8'b0010_0000,
    S_READ  = 8'b0100_0000,
    S_WRITE = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        // drop the word when the particle count is used up
        if (in_valid && !sts.full) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_ROW;
      end
      S_ROW: begin
        cmd.row    = 1'b1;
        state_next = S_CELL;
      end
      S_CELL: begin
        cmd.flat   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/cllb_dp.sv
// Datapath of the cell linked list builder: registers, cell index, head and link stores.
`default_nettype none

module cllb_dp import cllb_pkg::*; #(
  parameter int MAX_CELLS_PER_SIDE = 16,
  parameter int MAX_PARTICLES      = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire logic [23:0]       pos_x,
  input  wire logic [23:0]       pos_y,
  input  wire logic [23:0]       pos_z,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [15:0]            particle_index,
  output logic [11:0]            cell_index,
  output logic [16:0]            previous_head,
  output logic                   clamped
);

  localparam int NCells = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE;
  localparam int AW     = (NCells > 1) ? $clog2(NCells) : 1;
  localparam int CW     = (MAX_CELLS_PER_SIDE > 1) ? $clog2(MAX_CELLS_PER_SIDE) : 1;
  localparam int NW     = $clog2(MAX_CELLS_PER_SIDE + 1);
  localparam int PW     = $clog2(MAX_PARTICLES);
  localparam logic [6:0]  MaxSide = 7'(MAX_CELLS_PER_SIDE);
  localparam logic [20:0] MaxPart = 21'(MAX_PARTICLES);
  localparam logic [AW-1:0] LastCell = AW'(NCells - 1);

  logic [4:0]  cells_per_side;
  logic [31:0] cell_scale;
  logic [16:0] object_count;
  logic [16:0] next_particle;

  logic [23:0] pos_xr, pos_yr, pos_zr;
  logic [23:0] coord_x, coord_y, coord_z;
  logic [CW-1:0] ix, iy, iz;
  logic          clamp_any;
  logic [AW-1:0] row;
  logic [AW-1:0] cell_addr;
  logic [AW-1:0] clr_addr;

  logic [17:0] head_mem [NCells];
  logic [16:0] link_mem [MAX_PARTICLES];
  logic [17:0] head_rd;

  logic [6:0]    side7;
  logic [NW-1:0] n_eff;
  logic [20:0]   limit;
  logic [55:0]   prod_x, prod_y, prod_z;
  logic [16:0]   prev;
  logic [PW+16:0] link_addr_ext;
  logic [AW+11:0] cell_ext;

  always_comb begin
    side7 = {2'b00, cells_per_side};
    if (side7 == 7'd0) begin
      side7 = 7'd1;
    end else if (side7 > MaxSide) begin
      side7 = MaxSide;
    end
  end
  assign n_eff = side7[NW-1:0];

  assign limit = ({4'b0000, object_count} > MaxPart) ? MaxPart : {4'b0000, object_count};

  assign sts.full     = ({4'b0000, next_particle} >= limit);
  assign sts.clr_last = (clr_addr == LastCell);
  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_per_side <= 5'd16;
      cell_scale     <= 32'd65536;
      object_count   <= 17'd65536;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CELLS_PER_SIDE: cells_per_side <= cfg_data[4:0];
        REG_CELL_SCALE:     cell_scale     <= cfg_data;
        REG_OBJECT_COUNT:   object_count   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign prod_x = 56'(pos_xr) * 56'(cell_scale);
  assign prod_y = 56'(pos_yr) * 56'(cell_scale);
  assign prod_z = 56'(pos_zr) * 56'(cell_scale);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_xr <= pos_x;
      pos_yr <= pos_y;
      pos_zr <= pos_z;
    end
    if (cmd.mul) begin
      coord_x <= prod_x[55:32];
      coord_y <= prod_y[55:32];
      coord_z <= prod_z[55:32];
    end
    if (cmd.clamp) begin
      ix <= (coord_x >= 24'(n_eff)) ? CW'(n_eff - 1'b1) : coord_x[CW-1:0];
      iy <= (coord_y >= 24'(n_eff)) ? CW'(n_eff - 1'b1) : coord_y[CW-1:0];
      iz <= (coord_z >= 24'(n_eff)) ? CW'(n_eff - 1'b1) : coord_z[CW-1:0];
      clamp_any <= (coord_x >= 24'(n_eff)) || (coord_y >= 24'(n_eff))
                || (coord_z >= 24'(n_eff));
    end
    if (cmd.row) begin
      row <= AW'(AW'(ix) * AW'(n_eff) + AW'(iy));
    end
    if (cmd.flat) begin
      cell_addr <= AW'(row * AW'(n_eff) + AW'(iz));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      head_mem[clr_addr] <= '0;
    end else if (cmd.commit) begin
      head_mem[cell_addr] <= {1'b1, next_particle};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      head_rd <= head_mem[cell_addr];
    end
  end

  assign prev          = head_rd[17] ? head_rd[16:0] : object_count;
  assign link_addr_ext = (PW+17)'(next_particle);
  assign cell_ext      = (AW+12)'(cell_addr);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      link_mem[link_addr_ext[PW-1:0]] <= prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_particle <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.commit) begin
        next_particle <= next_particle + 1'b1;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      particle_index <= next_particle[15:0];
      cell_index     <= cell_ext[11:0];
      previous_head  <= prev;
      clamped        <= clamp_any;
    end
  end

endmodule

`default_nettype wire

FILE: design/cell_linked_list_builder.sv
// Top level of the cell linked list builder.
//
//   channel  direction  handshake              word
//   cfg      in         cfg_write              cfg_index, cfg_data
//   in       in         in_valid / in_ready    pos_x, pos_y, pos_z
//   out      out        out_valid / out_ready  particle_index, cell_index,
//                                              previous_head, clamped
//
// A particle passes from acceptance to its result word through the load, one multiply
// step, clamp, two cell index multiply-add steps, the registered head memory
// read, and the head write; the next particle is taken only after that head write.
// After reset a clearing pass walks the head memory, one cell a cycle, over all
// MAX_CELLS_PER_SIDE**3 cells (4096 by default); in_ready stays low until done.
// A result word waiting in the output register holds the next particle at its
// head write; a word past the particle count is accepted and dropped.
`default_nettype none
`include "cell_linked_list_builder_macros.svh"

module cell_linked_list_builder import cllb_pkg::*; #(
  parameter int MAX_CELLS_PER_SIDE = 16,
  parameter int MAX_PARTICLES      = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [23:0]       pos_x,
  input  wire logic [23:0]       pos_y,
  input  wire logic [23:0]       pos_z,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [15:0]            particle_index,
  output logic [11:0]            cell_index,
  output logic [16:0]            previous_head,
  output logic                   clamped
);

  cmd_t cmd;
  sts_t sts;

  cllb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cllb_dp #(
    .MAX_CELLS_PER_SIDE (MAX_CELLS_PER_SIDE),
    .MAX_PARTICLES      (MAX_PARTICLES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .particle_index (particle_index),
    .cell_index     (cell_index),
    .previous_head  (previous_head),
    .clamped        (clamped)
  );

  `CLLB_ASSERT_NOW(a_no_accept_in_clear, clk, rst, in_ready, !cmd.clear)
  `CLLB_ASSERT_NOW(a_commit_when_free, clk, rst, cmd.commit, !sts.out_busy)
  `CLLB_ASSERT_NEXT(a_commit_shows_word, clk, rst, cmd.commit, out_valid)
  `CLLB_ASSERT_NOW(a_load_not_full, clk, rst, cmd.load, in_ready && !sts.full)

endmodule

`default_nettype wire

FILE: sim/cell_list_checker.sv
`timescale 1ns / 100ps
// Checker for the cell linked list builder: mirrors registers, predicts each word and compares.
module cell_list_checker import cllb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [23:0]       pos_x,
  input  logic [23:0]       pos_y,
  input  logic [23:0]       pos_z,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [15:0]       particle_index,
  input  logic [11:0]       cell_index,
  input  logic [16:0]       previous_head,
  input  logic              clamped,
  output int                fail_count,
  output int                pending_words,
  output int                linked_words,
  output int                clamped_words,
  output int                dropped_words,
  output logic [16:0]       next_index
);

  localparam int SIDE_MAX  = 16;
  localparam int COUNT_MAX = 65536;
  localparam int CELLS     = SIDE_MAX * SIDE_MAX * SIDE_MAX;

  typedef struct packed {
    logic [15:0] index;
    logic [11:0] cell_id;
    logic [16:0] prev_head;
    logic        clamp;
  } placement_t;

  logic [4:0]  grid_side;
  logic [31:0] grid_scale;
  logic [16:0] marker;
  logic [16:0] cell_heads [CELLS];
  bit          cell_filled [CELLS];
  logic [16:0] particle_next;
  placement_t  placements [$];
  int          fails, linked, clamps, drops;

  task automatic report_mismatch(input string msg);
    if (fails < 40) $display("%0t ns mismatch: %s", $time, msg);
    fails++;
  endtask

  function automatic logic [4:0] axis_cell(input logic [23:0] pos, input logic [4:0] side,
                                           output logic hit);
    logic [55:0] prod;
    prod = 56'(pos) * 56'(grid_scale);
    hit = (prod[55:32] >= 24'(side));
    axis_cell = hit ? side - 5'd1 : prod[36:32];
  endfunction

  task automatic link_particle(input logic [23:0] x, input logic [23:0] y,
                               input logic [23:0] z);
    logic [4:0]  side, cx, cy, cz;
    logic [16:0] limit;
    logic        hx, hy, hz;
    int          slot;
    placement_t  word;
    side  = (grid_side == 5'd0) ? 5'd1 : (grid_side > 5'(SIDE_MAX)) ? 5'(SIDE_MAX) : grid_side;
    limit = (marker > 17'(COUNT_MAX)) ? 17'(COUNT_MAX) : marker;
    if (particle_next >= limit) begin
      drops++;
      return;
    end
    cx = axis_cell(x, side, hx);
    cy = axis_cell(y, side, hy);
    cz = axis_cell(z, side, hz);
    slot = (int'(cx) * int'(side) + int'(cy)) * int'(side) + int'(cz);
    word.index     = particle_next[15:0];
    word.cell_id   = 12'(slot);
    word.prev_head = cell_filled[slot] ? cell_heads[slot] : marker;
    word.clamp     = hx | hy | hz;
    cell_heads[slot]  = particle_next;
    cell_filled[slot] = 1'b1;
    particle_next     = particle_next + 17'd1;
    linked++;
    if (word.clamp) clamps++;
    placements.push_back(word);
  endtask

  always @(posedge clk) begin : watch
    placement_t got, want;
    if (rst) begin
      grid_side     = 5'(SIDE_MAX);
      grid_scale    = 32'd65536;
      marker        = 17'(COUNT_MAX);
      particle_next = '0;
      for (int i = 0; i < CELLS; i++) cell_filled[i] = 1'b0;
      placements.delete();
      fails  = 0;
      linked = 0;
      clamps = 0;
      drops  = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CELLS_PER_SIDE: grid_side  = cfg_data[4:0];
          REG_CELL_SCALE:     grid_scale = cfg_data[31:0];
          REG_OBJECT_COUNT:   marker     = cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{particle_index, cell_index, previous_head, clamped};
        if (placements.size() == 0) begin
          report_mismatch($sformatf("unexpected word index %0d cell %0d head %0d",
                                    got.index, got.cell_id, got.prev_head));
        end else begin
          want = placements.pop_front();
          if (got.index !== want.index)
            report_mismatch($sformatf("particle_index got %0d, expected %0d",
                                      got.index, want.index));
          if (got.cell_id !== want.cell_id)
            report_mismatch($sformatf("particle %0d cell_index got %0d, expected %0d",
                                      want.index, got.cell_id, want.cell_id));
          if (got.prev_head !== want.prev_head)
            report_mismatch($sformatf("particle %0d previous_head got %0d, expected %0d",
                                      want.index, got.prev_head, want.prev_head));
          if (got.clamp !== want.clamp)
            report_mismatch($sformatf("particle %0d clamped got %0b, expected %0b",
                                      want.index, got.clamp, want.clamp));
        end
      end
      if (in_valid && in_ready) link_particle(pos_x, pos_y, pos_z);
    end
    fail_count    <= fails;
    pending_words <= placements.size();
    linked_words  <= linked;
    clamped_words <= clamps;
    dropped_words <= drops;
    next_index    <= particle_next;
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the cell linked list builder: clock, reset, stimulus and verdict.
module tb;
  import cllb_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [23:0]       pos_x = '0;
  logic [23:0]       pos_y = '0;
  logic [23:0]       pos_z = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [15:0]       particle_index;
  logic [11:0]       cell_index;
  logic [16:0]       previous_head;
  logic              clamped;

  int          fail_count, pending_words, linked_words, clamped_words, dropped_words;
  logic [16:0] next_index;

  bit          in_steady = 1'b0;
  bit          out_steady = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned box_span = 24'hFFFFFF;

  cell_linked_list_builder dut (.*);

  cell_list_checker link_check (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("cell_linked_list_builder test failed");
    $finish;
  end

  task automatic configure(input logic [31:0] side_word, input logic [31:0] scale_word,
                           input logic [31:0] count_word);
    cfg_write <= 1'b1;
    cfg_index <= REG_CELLS_PER_SIDE;
    cfg_data  <= side_word;
    @(posedge clk);
    cfg_index <= REG_CELL_SCALE;
    cfg_data  <= scale_word;
    @(posedge clk);
    cfg_index <= REG_OBJECT_COUNT;
    cfg_data  <= count_word;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_position(input logic [23:0] x, input logic [23:0] y,
                               input logic [23:0] z);
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    pos_z    <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, wait for every word, then let dropped items clear the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_pos();
    case ($urandom_range(0, 9))
      0:       rand_pos = 24'($urandom);
      1:       rand_pos = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
      default: rand_pos = 24'($urandom_range(0, box_span - 1));
    endcase
  endfunction

  task automatic random_phase(input int unsigned items, input bit hold);
    logic [4:0]  side;
    int unsigned side_eff, box_units;
    logic [31:0] side_word, scale_word, count_word;
    case ($urandom_range(0, 9))
      0:       side = 5'd1;
      1:       side = 5'd16;
      2:       side = 5'd0;
      3:       side = 5'd31;
      default: side = 5'($urandom_range(1, 16));
    endcase
    side_eff  = (side == 0) ? 1 : (side > 16) ? 16 : side;
    side_word = ($urandom & ~32'h1F) | 32'(side);
    box_units = $urandom_range(1, 256);
    box_span  = box_units << 16;
    case ($urandom_range(0, 11))
      0:       scale_word = 32'h0;
      1:       scale_word = 32'hFFFFFFFF;
      2:       scale_word = $urandom;
      default: scale_word = (side_eff << 16) / box_units;
    endcase
    if (hold) count_word = 32'd65536;
    else begin
      case ($urandom_range(0, 11))
        0:       count_word = 32'd131071;
        1:       count_word = 32'(next_index) + $urandom_range(0, 30);
        2:       count_word = 32'd0;
        3:       count_word = 32'd65536;
        default: count_word = $urandom_range(int'(next_index) + 300, 131071);
      endcase
    end
    configure(side_word, scale_word, count_word);
    in_steady  = hold || ($urandom_range(0, 3) == 0);
    out_steady = $urandom_range(0, 3) == 0;
    if (hold) hold_request = 1'b1;
    repeat (items) send_position(rand_pos(), rand_pos(), rand_pos());
    in_steady  = 1'b0;
    out_steady = 1'b0;
    drain();
  endtask

  initial begin : receiver
    int unsigned gap;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = out_steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int random_phases;
    random_phases = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 16 cells per side, unit scale
    send_position(24'h000000, 24'h000000, 24'h000000);
    send_position(24'h000000, 24'h000000, 24'h000000);
    send_position(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_position(24'h0FFFFF, 24'h0FFFFF, 24'h0FFFFF);
    send_position(24'h100000, 24'h000000, 24'h000000);
    send_position(24'h000000, 24'h100000, 24'h000000);
    send_position(24'h000000, 24'h000000, 24'h100000);
    send_position(24'h050000, 24'h0A0000, 24'h0F0000);
    drain();

    // zero grid size, full scale, count above the particle limit
    configure(32'd0, 32'hFFFFFFFF, 32'd131071);
    send_position(24'h000000, 24'h000000, 24'h000000);
    send_position(24'h000001, 24'h000001, 24'h000001);
    send_position(24'h000002, 24'h000000, 24'h000000);
    send_position(24'hFFFFFF, 24'h000000, 24'hFFFFFF);
    drain();

    // oversized grid, zero scale
    configure(32'd31, 32'h0, 32'd65536);
    send_position(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_position(24'h123456, 24'h654321, 24'hABCDEF);
    drain();

    // count two past the current particle: the rest are dropped
    configure(32'd16, 32'h00100000, 32'(next_index) + 32'd2);
    send_position(24'h008000, 24'h004000, 24'h00C000);
    send_position(24'h008000, 24'h004000, 24'h00C000);
    send_position(24'h00FFFF, 24'h000000, 24'h000000);
    send_position(24'h010000, 24'h000000, 24'h000000);
    drain();

    configure(32'd16, 32'd65536, 32'd0);
    send_position(24'h000000, 24'h000000, 24'h000000);
    send_position(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    drain();

    // empty cells read back the marker value
    configure(32'd2, 32'd65536, 32'd131071);
    send_position(24'h010000, 24'h010000, 24'h010000);
    send_position(24'h000000, 24'h000000, 24'h000000);
    send_position(24'h018000, 24'h000000, 24'h010000);
    drain();

    random_phase(80, 1'b1);
    random_phases++;
    while (linked_words + dropped_words < 1200) begin
      random_phase($urandom_range(40, 160), 1'b0);
      random_phases++;
    end

    $display("%0d positions linked (%0d clamped), %0d dropped past the particle count",
             linked_words, clamped_words, dropped_words);
    $display("6 directed register settings, %0d random ones, one long output stall",
             random_phases);
    if (fail_count == 0) begin
      $display("cell_linked_list_builder test passed");
    end else begin
      $display("cell_linked_list_builder test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/cllb_pkg.sv
design/cllb_ctrl.sv
design/cllb_dp.sv
design/cell_linked_list_builder.sv
sim/cell_list_checker.sv
sim/tb.sv
